>>> rtl/bkrd_pkg.sv
// ----------------------------------------------------------------------------
// Boot keyboard report decoder package
// Shared types, usage and character codes, and the usage-to-character map.
// ----------------------------------------------------------------------------
package bkrd_pkg;

  localparam int SLOT_COUNT = 6;

  typedef logic [7:0] key_t;
  typedef logic [8:0] code_t;
  typedef key_t [SLOT_COUNT-1:0] key_vec_t;

  // What one lane reports about its slot.
  typedef struct packed {
    logic                  nz;       // slot holds a key
    logic [SLOT_COUNT-1:0] eq_held;  // matches each stored key code
    logic [SLOT_COUNT-1:0] eq_slot;  // matches each slot of this report
    logic                  mapped;   // usage maps to a character
    code_t                 code;     // mapped character or navigation code
  } lane_res_t;

  typedef lane_res_t [SLOT_COUNT-1:0] lane_vec_t;

  // Usage codes.
  localparam key_t USE_RIGHT     = 8'h4f;
  localparam key_t USE_LEFT      = 8'h50;
  localparam key_t USE_DOWN      = 8'h51;
  localparam key_t USE_UP        = 8'h52;
  localparam key_t USE_HOME      = 8'h4a;
  localparam key_t USE_END       = 8'h4d;
  localparam key_t USE_DELETE    = 8'h4c;
  localparam key_t USE_ENTER     = 8'h28;
  localparam key_t USE_SPACE     = 8'h2c;
  localparam key_t USE_BACKSPACE = 8'h2a;
  localparam key_t USE_TAB       = 8'h2b;
  localparam key_t USE_MINUS     = 8'h2d;
  localparam key_t USE_EQUAL     = 8'h2e;
  localparam key_t USE_LBRACKET  = 8'h2f;
  localparam key_t USE_RBRACKET  = 8'h30;
  localparam key_t USE_LETTER_A  = 8'h04;
  localparam key_t USE_LETTER_Z  = 8'h1d;
  localparam key_t USE_DIGIT_1   = 8'h1e;
  localparam key_t USE_DIGIT_0   = 8'h27;

  // Result codes.
  localparam code_t CODE_UP     = 9'h100;
  localparam code_t CODE_DOWN   = 9'h101;
  localparam code_t CODE_LEFT   = 9'h102;
  localparam code_t CODE_RIGHT  = 9'h103;
  localparam code_t CODE_HOME   = 9'h104;
  localparam code_t CODE_END    = 9'h105;
  localparam code_t CODE_DELETE = 9'h106;
  localparam code_t CODE_NONE   = 9'h000;

  localparam logic [7:0] ASC_LF     = 8'd10;
  localparam logic [7:0] ASC_BS     = 8'd8;
  localparam logic [7:0] ASC_TAB    = 8'd9;
  localparam logic [7:0] ASC_SPACE  = 8'd32;
  localparam logic [7:0] ASC_LOWER_A = 8'h61;
  localparam logic [7:0] ASC_UPPER_A = 8'h41;
  localparam logic [7:0] ASC_ONE    = 8'h31;
  localparam logic [7:0] ASC_ZERO   = 8'h30;

  // Shifted digit row, usage order 1..9 then 0.
  function automatic logic [7:0] shift_digit(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h21; // !
      4'd1:    ch = 8'h40; // @
      4'd2:    ch = 8'h23; // #
      4'd3:    ch = 8'h24; // $
      4'd4:    ch = 8'h25; // %
      4'd5:    ch = 8'h5e; // ^
      4'd6:    ch = 8'h26; // &
      4'd7:    ch = 8'h2a; // *
      4'd8:    ch = 8'h28; // (
      4'd9:    ch = 8'h29; // )
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Maps a usage to its code; zero means the usage is not mapped.
  function automatic code_t map_usage(input key_t k, input logic shifted);
    code_t c;
    key_t  idx;
    c   = CODE_NONE;
    idx = '0;
    case (k)
      USE_RIGHT:     c = CODE_RIGHT;
      USE_LEFT:      c = CODE_LEFT;
      USE_DOWN:      c = CODE_DOWN;
      USE_UP:        c = CODE_UP;
      USE_HOME:      c = CODE_HOME;
      USE_END:       c = CODE_END;
      USE_DELETE:    c = CODE_DELETE;
      USE_ENTER:     c = {1'b0, ASC_LF};
      USE_SPACE:     c = {1'b0, ASC_SPACE};
      USE_BACKSPACE: c = {1'b0, ASC_BS};
      USE_TAB:       c = {1'b0, ASC_TAB};
      USE_MINUS:     c = shifted ? 9'h05f : 9'h02d;
      USE_EQUAL:     c = shifted ? 9'h02b : 9'h03d;
      USE_LBRACKET:  c = shifted ? 9'h07b : 9'h05b;
      USE_RBRACKET:  c = shifted ? 9'h07d : 9'h05d;
      default: begin
        if (k >= USE_LETTER_A && k <= USE_LETTER_Z) begin
          idx = k - USE_LETTER_A;
          c   = {1'b0, (shifted ? ASC_UPPER_A : ASC_LOWER_A) + idx};
        end else if (k >= USE_DIGIT_1 && k <= USE_DIGIT_0) begin
          idx = k - USE_DIGIT_1;
          if (shifted) begin
            c = {1'b0, shift_digit(idx[3:0])};
          end else if (k == USE_DIGIT_0) begin
            c = {1'b0, ASC_ZERO};
          end else begin
            c = {1'b0, ASC_ONE + idx};
          end
        end
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/bkrd_if.sv
// ----------------------------------------------------------------------------
// Boot keyboard report decoder channels
// Valid/ready channels for input reports and decoded key words.
// ----------------------------------------------------------------------------
interface bkrd_in_if;
  import bkrd_pkg::*;

  logic valid;
  logic ready;
  logic transfer_ok;
  logic [7:0] modifiers;
  key_t key_slot_0;
  key_t key_slot_1;
  key_t key_slot_2;
  key_t key_slot_3;
  key_t key_slot_4;
  key_t key_slot_5;

  modport source (
    output valid, transfer_ok, modifiers,
    output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    input  ready
  );
  modport sink (
    input  valid, transfer_ok, modifiers,
    input  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    output ready
  );
endinterface

interface bkrd_out_if;
  import bkrd_pkg::*;

  logic  valid;
  logic  ready;
  logic  key_found;
  code_t key_code;

  modport source (output valid, key_found, key_code, input ready);
  modport sink (input valid, key_found, key_code, output ready);
endinterface

>>> rtl/bkrd_lane.sv
// ----------------------------------------------------------------------------
// Boot keyboard report decoder slot lane
// Compares one slot against the stored keys and the report, and maps it.
// ----------------------------------------------------------------------------
module bkrd_lane (
  input  bkrd_pkg::key_t      slot,
  input  logic                shifted,
  input  bkrd_pkg::key_vec_t  held,
  input  bkrd_pkg::key_vec_t  slots,
  output bkrd_pkg::lane_res_t res
);
  import bkrd_pkg::*;

  code_t code;

  // Character lookup for this slot.
  assign code = map_usage(slot, shifted);

  // Equality against every stored key and every slot of the report.
  always_comb begin
    res.nz     = (slot != '0);
    res.mapped = (code != CODE_NONE);
    res.code   = code;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      res.eq_held[j] = (held[j] == slot);
      res.eq_slot[j] = (slots[j] == slot);
    end
  end

endmodule

>>> rtl/bkrd_merge.sv
// ----------------------------------------------------------------------------
// Boot keyboard report decoder merge stage
// Resolves slot order, picks the first new mapped key and updates the store.
// ----------------------------------------------------------------------------
module bkrd_merge (
  input  bkrd_pkg::lane_vec_t lanes,
  input  bkrd_pkg::key_vec_t  slots,
  input  bkrd_pkg::key_vec_t  held,
  output bkrd_pkg::key_vec_t  held_upd,
  output logic                found,
  output bkrd_pkg::code_t     code
);
  import bkrd_pkg::*;

  logic [SLOT_COUNT-1:0] rec;

  // Walk the slots in order. A slot recorded earlier in this report has
  // replaced its stored key, so later slots compare against the new code.
  always_comb begin
    logic hit;
    logic stop;
    hit   = 1'b0;
    stop  = 1'b0;
    found = 1'b0;
    code  = CODE_NONE;
    rec   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit = 1'b0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        if (j < i && rec[j]) begin
          hit = hit | lanes[i].eq_slot[j];
        end else begin
          hit = hit | lanes[i].eq_held[j];
        end
      end
      if (!stop && lanes[i].nz && !hit) begin
        rec[i] = 1'b1;
        if (lanes[i].mapped) begin
          stop  = 1'b1;
          found = 1'b1;
          code  = lanes[i].code;
        end
      end
    end
  end

  // Recorded slots take the new code; if no key is found, empty slots clear.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (rec[i]) begin
        held_upd[i] = slots[i];
      end else if (!found && !lanes[i].nz) begin
        held_upd[i] = '0;
      end else begin
        held_upd[i] = held[i];
      end
    end
  end

endmodule

>>> rtl/boot_keyboard_report_decoder.sv
// ----------------------------------------------------------------------------
// Boot keyboard report decoder
// Turns HID boot keyboard reports into the first newly pressed character.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Word
//  ---------+-----------+---------------------------------------------------
//  in_ch    | sink      | transfer_ok, modifiers, key_slot_0 .. key_slot_5
//  out_ch   | source    | key_found, key_code
//
// One report is taken every cycle while the output register is free or read;
// each yields one result word in the next cycle. The six slot lanes and merge
// stage are combinational; a good report updates the stored keys as it is taken.
// Reset clears the stored keys and the output valid flag.
// A stalled output holds the input off only while its register stays full.
// ----------------------------------------------------------------------------
module boot_keyboard_report_decoder (
  input logic     clk,
  input logic     rst_n,
  bkrd_in_if.sink    in_ch,
  bkrd_out_if.source out_ch
);
  import bkrd_pkg::*;

  key_vec_t  held_r;
  key_vec_t  held_nxt;
  key_vec_t  held_upd;
  key_vec_t  slots;
  lane_vec_t lanes;
  logic      shifted;
  logic      accept;
  logic      found;
  code_t     code;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      out_found_r;
  code_t     out_code_r;

  // Gather the report slots.
  assign slots[0] = in_ch.key_slot_0;
  assign slots[1] = in_ch.key_slot_1;
  assign slots[2] = in_ch.key_slot_2;
  assign slots[3] = in_ch.key_slot_3;
  assign slots[4] = in_ch.key_slot_4;
  assign slots[5] = in_ch.key_slot_5;
  assign shifted  = (in_ch.modifiers[1:0] != 2'b00);

  // One lane per slot.
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_lane
    bkrd_lane u_lane (
      .slot    (slots[g]),
      .shifted (shifted),
      .held    (held_r),
      .slots   (slots),
      .res     (lanes[g])
    );
  end

  bkrd_merge u_merge (
    .lanes    (lanes),
    .slots    (slots),
    .held     (held_r),
    .held_upd (held_upd),
    .found    (found),
    .code     (code)
  );

  // Handshake: a word is taken whenever the output register is free or leaving.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // A failed transfer leaves the stored keys alone.
  always_comb begin
    held_nxt = held_r;
    if (accept && in_ch.transfer_ok) begin
      held_nxt = held_upd;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_found_r <= in_ch.transfer_ok & found;
      out_code_r  <= in_ch.transfer_ok ? code : CODE_NONE;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_found = out_found_r;
  assign out_ch.key_code  = out_code_r;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Boot keyboard report decoder testbench
// Drives keyboard reports into the decoder with random gaps and output
// stalls. A behavioural copy of the held-key tracking predicts each decoded
// key word, and every word that leaves the block is checked against it.
// ----------------------------------------------------------------------------
module testbench;
  import bkrd_pkg::*;

  // One report as it enters the block.
  typedef struct packed {
    logic       transfer_ok;
    logic [7:0] modifiers;
    key_vec_t   slots;
  } report_t;

  // One decoded key word.
  typedef struct packed {
    logic  found;
    code_t code;
  } key_word_t;

  logic clk;
  logic rst_n;

  bkrd_in_if  in_ch ();
  bkrd_out_if out_ch ();

  boot_keyboard_report_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_t      pressed_keys [SLOT_COUNT];
  key_word_t pending_keys [$];
  int        bad_words;
  bit        no_idle;
  int        hold_req;

  // Clock: 20 time units per period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Translates a usage code into its character or navigation code.
  function automatic code_t usage_to_char(key_t k, bit shifted);
    string lower_row;
    string upper_row;
    string digit_row;
    string symbol_row;
    string punct_plain;
    string punct_shift;
    lower_row   = "abcdefghijklmnopqrstuvwxyz";
    upper_row   = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    digit_row   = "1234567890";
    symbol_row  = "!@#$%^&*()";
    punct_plain = "-=[]";
    punct_shift = "_+{}";
    case (k)
      USE_RIGHT:     return CODE_RIGHT;
      USE_LEFT:      return CODE_LEFT;
      USE_DOWN:      return CODE_DOWN;
      USE_UP:        return CODE_UP;
      USE_HOME:      return CODE_HOME;
      USE_END:       return CODE_END;
      USE_DELETE:    return CODE_DELETE;
      USE_ENTER:     return code_t'(ASC_LF);
      USE_SPACE:     return code_t'(ASC_SPACE);
      USE_BACKSPACE: return code_t'(ASC_BS);
      USE_TAB:       return code_t'(ASC_TAB);
      default: ;
    endcase
    if (k >= USE_MINUS && k <= USE_RBRACKET) begin
      return shifted ? code_t'(punct_shift[k - USE_MINUS])
                     : code_t'(punct_plain[k - USE_MINUS]);
    end
    if (k >= USE_LETTER_A && k <= USE_LETTER_Z) begin
      return shifted ? code_t'(upper_row[k - USE_LETTER_A])
                     : code_t'(lower_row[k - USE_LETTER_A]);
    end
    if (k >= USE_DIGIT_1 && k <= USE_DIGIT_0) begin
      return shifted ? code_t'(symbol_row[k - USE_DIGIT_1])
                     : code_t'(digit_row[k - USE_DIGIT_1]);
    end
    return CODE_NONE;
  endfunction

  // Updates the held keys for one accepted report and returns the key word due.
  function automatic key_word_t predict_key(report_t r);
    key_word_t w;
    bit        shifted;
    bit        held;
    code_t     c;
    w = '0;
    if (!r.transfer_ok) return w;
    shifted = (r.modifiers[1:0] != 2'b00);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (r.slots[i] != '0) begin
        held = 1'b0;
        for (int j = 0; j < SLOT_COUNT; j++)
          if (pressed_keys[j] == r.slots[i]) held = 1'b1;
        if (!held) begin
          pressed_keys[i] = r.slots[i];
          c = usage_to_char(r.slots[i], shifted);
          if (c != CODE_NONE) begin
            w.found = 1'b1;
            w.code  = c;
            return w;
          end
        end
      end
    end
    // Nothing new and mapped: release the keys whose slots are now empty.
    for (int i = 0; i < SLOT_COUNT; i++)
      if (r.slots[i] == '0) pressed_keys[i] = '0;
    return w;
  endfunction

  function automatic report_t make_report(bit ok, logic [7:0] mods, key_t s0, key_t s1,
                                          key_t s2, key_t s3, key_t s4, key_t s5);
    report_t r;
    r.transfer_ok = ok;
    r.modifiers   = mods;
    r.slots       = {s5, s4, s3, s2, s1, s0};
    return r;
  endfunction

  function automatic void log_bad(string what, key_word_t want, key_word_t got);
    bad_words++;
    if (bad_words <= 10)
      $display("%s: expected found=%0d code=%03h, got found=%0d code=%03h",
               what, want.found, want.code, got.found, got.code);
  endfunction

  // Offers one report after a random gap and predicts its word once taken.
  task automatic send_report(report_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.transfer_ok <= r.transfer_ok;
    in_ch.modifiers   <= r.modifiers;
    in_ch.key_slot_0  <= r.slots[0];
    in_ch.key_slot_1  <= r.slots[1];
    in_ch.key_slot_2  <= r.slots[2];
    in_ch.key_slot_3  <= r.slots[3];
    in_ch.key_slot_4  <= r.slots[4];
    in_ch.key_slot_5  <= r.slots[5];
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_keys.push_back(predict_key(r));
  endtask

  // Withdraws the sender and waits for every predicted word to arrive.
  task automatic drain;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: stalls a random number of cycles before each word.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Checks every word that leaves the block against the oldest prediction.
  always @(posedge clk) begin
    key_word_t got;
    key_word_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.found = out_ch.key_found;
      got.code  = out_ch.key_code;
      if (pending_keys.size() == 0) begin
        log_bad("unexpected key word", '0, got);
      end else begin
        want = pending_keys.pop_front();
        if (got.found !== want.found || got.code !== want.code)
          log_bad("key word mismatch", want, got);
      end
    end
  end

  // Every mapping class, shift selection, failed transfers and held keys.
  task automatic test_directed;
    key_t    specials [15];
    report_t r;
    key_t    z;
    specials = '{USE_ENTER, USE_BACKSPACE, USE_TAB, USE_SPACE, USE_MINUS, USE_EQUAL,
                 USE_LBRACKET, USE_RBRACKET, USE_RIGHT, USE_LEFT, USE_DOWN, USE_UP,
                 USE_HOME, USE_DELETE, USE_END};
    z = '0;
    send_report(make_report(1'b1, 8'h00, USE_LETTER_A, z, z, z, z, z));
    // The same key still down yields nothing.
    send_report(make_report(1'b1, 8'h00, USE_LETTER_A, z, z, z, z, z));
    send_report(make_report(1'b1, 8'h02, USE_LETTER_A, USE_LETTER_Z, z, z, z, z));
    // A failed transfer must leave the held keys alone.
    send_report(make_report(1'b0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_report(make_report(1'b1, 8'h00, z, z, z, z, z, z));
    // Unmapped new keys are recorded and the scan carries on.
    send_report(make_report(1'b1, 8'hfc, 8'hff, 8'h01, USE_DIGIT_1, z, z, z));
    send_report(make_report(1'b1, 8'h01, USE_DIGIT_0, z, z, z, z, z));
    // A code repeated within one report counts as held in its later slot.
    send_report(make_report(1'b1, 8'h00, 8'h60, 8'h60, USE_ENTER, z, z, z));
    send_report(make_report(1'b1, 8'h00, z, z, z, z, z, z));
    for (int i = 0; i < 15; i++) begin
      r = make_report(1'b1, (i % 2) ? 8'h02 : 8'h00, z, z, z, z, z, z);
      r.slots[i % SLOT_COUNT] = specials[i];
      send_report(r);
    end
    send_report(make_report(1'b1, 8'h00, z, z, z, z, z, z));
    drain();
  endtask

  function automatic key_t pick_usage(report_t r);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return key_t'($urandom_range(USE_LETTER_A, USE_RBRACKET));
    if (sel < 60) return key_t'($urandom_range(USE_HOME, USE_UP));
    if (sel < 82) return key_t'($urandom_range(0, 255));
    return r.slots[$urandom_range(0, SLOT_COUNT - 1)];
  endfunction

  // Typing sequences: keys pressed and released one at a time, with noise.
  task automatic test_random_typing(int count);
    report_t cur;
    report_t junk;
    int      sel;
    int      s;
    cur = '0;
    for (int n = 0; n < count; n++) begin
      // A stretch with no idling on either side.
      no_idle = (n >= count / 3 && n < count / 3 + 200);
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        junk.transfer_ok = 1'b0;
        junk.modifiers   = 8'($urandom_range(0, 255));
        for (int i = 0; i < SLOT_COUNT; i++) junk.slots[i] = key_t'($urandom_range(0, 255));
        send_report(junk);
      end else begin
        if (sel < 12) begin
          for (int i = 0; i < SLOT_COUNT; i++) cur.slots[i] = key_t'($urandom_range(0, 255));
        end else if (sel < 18) begin
          cur.slots = '0;
        end else begin
          s = $urandom_range(0, SLOT_COUNT - 1);
          if (cur.slots[s] != '0 && $urandom_range(0, 2) == 0) cur.slots[s] = '0;
          else cur.slots[s] = pick_usage(cur);
        end
        cur.transfer_ok = 1'b1;
        cur.modifiers   = 8'($urandom_range(0, 255));
        send_report(cur);
      end
    end
    no_idle = 1'b0;
    drain();
  endtask

  // The receiver holds off for a long stretch while reports keep coming.
  task automatic test_output_backpressure;
    report_t r;
    key_t    z;
    z        = '0;
    no_idle  = 1'b1;
    hold_req = 60;
    for (int n = 0; n < 30; n++) begin
      r = make_report(1'b1, 8'($urandom_range(0, 3)), z, z, z, z, z, z);
      r.slots[n % SLOT_COUNT] = (n % 2) ? key_t'(0) :
                                key_t'($urandom_range(USE_LETTER_A, USE_LETTER_Z));
      send_report(r);
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    rst_n             = 1'b0;
    no_idle           = 1'b0;
    hold_req          = 0;
    bad_words         = 0;
    in_ch.valid       = 1'b0;
    in_ch.transfer_ok = 1'b0;
    in_ch.modifiers   = '0;
    in_ch.key_slot_0  = '0;
    in_ch.key_slot_1  = '0;
    in_ch.key_slot_2  = '0;
    in_ch.key_slot_3  = '0;
    in_ch.key_slot_4  = '0;
    in_ch.key_slot_5  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) pressed_keys[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_output_backpressure();
    test_random_typing(1500);
    if (bad_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
